// ===== sv/lkv_pkg.sv =====
`timescale 1ns / 1ps

package lkv_pkg;

  // field widths of one item
  localparam int KeyW  = 32;
  localparam int DataW = 32;
  localparam int CapW  = 5;

  // defaults for the top-level parameters and the capacity register
  localparam int DefaultMaxEntries = 16;
  localparam int DefaultCapacity   = 16;
  localparam int CmdQueueDepth     = 2;
  localparam int RspQueueDepth     = 2;

  // data returned by a get that misses
  localparam logic [DataW-1:0] MissData = '1;

  // operation codes
  typedef enum logic {
    OpGet = 1'b0,
    OpPut = 1'b1
  } op_e;

  // classified request between front and back
  typedef struct packed {
    op_e              op;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] value;
  } req_t;

  // one result beat
  typedef struct packed {
    logic             found;
    logic [DataW-1:0] data;
    logic             evicted;
    logic [KeyW-1:0]  evicted_key;
  } rsp_t;

endpackage

// ===== sv/lkv_ram.sv =====
`timescale 1ns / 1ps

module lkv_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lkv_fifo.sv =====
`timescale 1ns / 1ps

module lkv_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/lkv_front.sv =====
`timescale 1ns / 1ps

module lkv_front #(
  parameter int MaxEntries = lkv_pkg::DefaultMaxEntries,
  parameter int QueueDepth = lkv_pkg::CmdQueueDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            push,
  output logic                            full,
  input  logic                            cmd_i,
  input  logic [lkv_pkg::KeyW-1:0]        key_i,
  input  logic [lkv_pkg::DataW-1:0]       value_i,
  // capacity register write
  input  logic                            cfg_we_i,
  input  logic [lkv_pkg::CapW-1:0]        cfg_wdata_i,
  // request queue toward the back end
  output logic                            req_valid_o,
  output lkv_pkg::req_t                   req_o,
  input  logic                            req_pop_i,
  output logic [$clog2(MaxEntries+1)-1:0] cap_o
);

  localparam int CntW     = $clog2(MaxEntries + 1);
  localparam int ResetCap = (lkv_pkg::DefaultCapacity > MaxEntries) ? MaxEntries
                                                                     : lkv_pkg::DefaultCapacity;

  logic [CntW-1:0]  cap_q, cap_d;
  logic [31:0]      cap_wide;
  lkv_pkg::req_t    req_in;
  logic             q_empty;

  // effective capacity: zero reads as one, clamp to the table size
  always_comb begin
    cap_wide = 32'(cfg_wdata_i);
    cap_d    = cap_q;
    if (cfg_we_i) begin
      if (cap_wide == 32'd0) begin
        cap_d = CntW'(1);
      end else if (cap_wide > 32'(MaxEntries)) begin
        cap_d = CntW'(MaxEntries);
      end else begin
        cap_d = CntW'(cap_wide);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CntW'(ResetCap);
    end else begin
      cap_q <= cap_d;
    end
  end

  assign cap_o = cap_q;

  // classify the incoming beat
  always_comb begin
    req_in.op    = (cmd_i == 1'b1) ? lkv_pkg::OpPut : lkv_pkg::OpGet;
    req_in.key   = key_i;
    req_in.value = value_i;
  end

  // short queue that decouples the back end
  lkv_fifo #(
    .Width ($bits(lkv_pkg::req_t)),
    .Depth (QueueDepth)
  ) u_req_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (req_in),
    .full_o  (full),
    .pop_i   (req_pop_i),
    .rdata_o (req_o),
    .empty_o (q_empty)
  );

  assign req_valid_o = !q_empty;

endmodule

// ===== sv/lkv_back.sv =====
`timescale 1ns / 1ps

module lkv_back #(
  parameter int MaxEntries = lkv_pkg::DefaultMaxEntries
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  lkv_pkg::req_t                   req_i,
  output logic                            req_pop_o,
  input  logic [$clog2(MaxEntries+1)-1:0] cap_i,
  input  logic                            rsp_full_i,
  output logic                            rsp_push_o,
  output lkv_pkg::rsp_t                   rsp_o
);

  localparam int IdxW  = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW  = $clog2(MaxEntries + 1);
  localparam int EntW  = lkv_pkg::KeyW + lkv_pkg::DataW;
  localparam logic [CntW-1:0] LastPtr = CntW'(MaxEntries);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StScan   = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StUpdate = 3'd3;
  localparam logic [2:0] StDone   = 3'd4;

  // control state
  logic [2:0]            state_q, state_d;
  logic [CntW-1:0]       ptr_q, ptr_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [MaxEntries-1:0] valid_q, valid_d;
  logic [CntW-1:0]       occ_q, occ_d;
  logic                  hit_q, hit_d;
  logic                  old_any_q, old_any_d;
  logic                  free_any_q, free_any_d;

  // payload state
  logic [IdxW-1:0]              cmp_idx_q, cmp_idx_d;
  logic                         is_put_q, is_put_d;
  logic [lkv_pkg::KeyW-1:0]     key_q, key_d;
  logic [lkv_pkg::DataW-1:0]    value_q, value_d;
  logic [IdxW-1:0]              hit_idx_q, hit_idx_d;
  logic [IdxW-1:0]              hit_age_q, hit_age_d;
  logic [lkv_pkg::DataW-1:0]    hit_val_q, hit_val_d;
  logic [IdxW-1:0]              old_idx_q, old_idx_d;
  logic [IdxW-1:0]              old_age_q, old_age_d;
  logic [lkv_pkg::KeyW-1:0]     old_key_q, old_key_d;
  logic [IdxW-1:0]              free_idx_q, free_idx_d;
  logic [IdxW-1:0]              tgt_idx_q, tgt_idx_d;
  lkv_pkg::rsp_t                rsp_q, rsp_d;

  // memory ports
  logic [IdxW-1:0]  rd_addr;
  logic [EntW-1:0]  ent_rdata;
  logic             ent_we;
  logic [IdxW-1:0]  ent_waddr;
  logic [EntW-1:0]  ent_wdata;
  logic [IdxW-1:0]  age_rdata;
  logic             age_we;
  logic [IdxW-1:0]  age_wdata;

  // decide helpers
  logic                      ent_vld;
  logic [lkv_pkg::KeyW-1:0]  ent_key;
  logic [lkv_pkg::DataW-1:0] ent_val;
  logic                      evict;
  logic [IdxW-1:0]           slot;

  assign rd_addr = ptr_q[IdxW-1:0];
  assign ent_key = ent_rdata[EntW-1:lkv_pkg::DataW];
  assign ent_val = ent_rdata[lkv_pkg::DataW-1:0];
  assign ent_vld = valid_q[cmp_idx_q];

  // eviction choice, meaningful in the decide cycle
  assign evict = is_put_q && !hit_q && (occ_q >= cap_i) && old_any_q;
  assign slot  = evict ? old_idx_q : free_idx_q;

  // key/value entries
  lkv_ram #(
    .Width (EntW),
    .Depth (MaxEntries)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ent_rdata)
  );

  // recency ages, zero is most recent
  lkv_ram #(
    .Width (IdxW),
    .Depth (MaxEntries)
  ) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (age_we),
    .waddr_i (cmp_idx_q),
    .wdata_i (age_wdata),
    .raddr_i (rd_addr),
    .rdata_o (age_rdata)
  );

  // sequencer: scan pass, decide, age update pass, deliver
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    valid_d    = valid_q;
    occ_d      = occ_q;
    hit_d      = hit_q;
    old_any_d  = old_any_q;
    free_any_d = free_any_q;
    is_put_d   = is_put_q;
    key_d      = key_q;
    value_d    = value_q;
    hit_idx_d  = hit_idx_q;
    hit_age_d  = hit_age_q;
    hit_val_d  = hit_val_q;
    old_idx_d  = old_idx_q;
    old_age_d  = old_age_q;
    old_key_d  = old_key_q;
    free_idx_d = free_idx_q;
    tgt_idx_d  = tgt_idx_q;
    rsp_d      = rsp_q;
    req_pop_o  = 1'b0;
    rsp_push_o = 1'b0;
    ent_we     = 1'b0;
    ent_waddr  = slot;
    ent_wdata  = {key_q, value_q};
    age_we     = 1'b0;
    age_wdata  = '0;

    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          req_pop_o  = 1'b1;
          is_put_d   = (req_i.op == lkv_pkg::OpPut);
          key_d      = req_i.key;
          value_d    = req_i.value;
          hit_d      = 1'b0;
          old_any_d  = 1'b0;
          free_any_d = 1'b0;
          ptr_d      = '0;
          state_d    = StScan;
        end
      end

      StScan: begin
        // evaluate the entry read in the previous cycle
        if (cmp_vld_q) begin
          if (ent_vld && ent_key == key_q && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            hit_age_d = age_rdata;
            hit_val_d = ent_val;
          end
          if (ent_vld && (!old_any_q || age_rdata > old_age_q)) begin
            old_any_d = 1'b1;
            old_idx_d = cmp_idx_q;
            old_age_d = age_rdata;
            old_key_d = ent_key;
          end
          if (!ent_vld && !free_any_q) begin
            free_any_d = 1'b1;
            free_idx_d = cmp_idx_q;
          end
        end
        if (ptr_q != LastPtr) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = ptr_q[IdxW-1:0];
          ptr_d     = ptr_q + CntW'(1);
        end else begin
          state_d = StDecide;
        end
      end

      StDecide: begin
        tgt_idx_d         = hit_q ? hit_idx_q : slot;
        ent_waddr         = hit_q ? hit_idx_q : slot;
        ent_we            = is_put_q;
        rsp_d.found       = hit_q;
        rsp_d.data        = is_put_q ? '0 : (hit_q ? hit_val_q : lkv_pkg::MissData);
        rsp_d.evicted     = evict;
        rsp_d.evicted_key = evict ? old_key_q : '0;
        if (is_put_q && !hit_q) begin
          valid_d[slot] = 1'b1;
          if (!evict) begin
            occ_d = occ_q + CntW'(1);
          end
        end
        ptr_d   = '0;
        state_d = (is_put_q || hit_q) ? StUpdate : StDone;
      end

      StUpdate: begin
        // touched entry becomes zero, younger (or all on insert) age by one
        if (cmp_vld_q) begin
          if (cmp_idx_q == tgt_idx_q) begin
            age_we    = 1'b1;
            age_wdata = '0;
          end else if (ent_vld && (!hit_q || age_rdata < hit_age_q)) begin
            age_we    = 1'b1;
            age_wdata = age_rdata + IdxW'(1);
          end
        end
        if (ptr_q != LastPtr) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = ptr_q[IdxW-1:0];
          ptr_d     = ptr_q + CntW'(1);
        end else begin
          state_d = StDone;
        end
      end

      StDone: begin
        if (!rsp_full_i) begin
          rsp_push_o = 1'b1;
          state_d    = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ptr_q      <= '0;
      cmp_vld_q  <= 1'b0;
      valid_q    <= '0;
      occ_q      <= '0;
      hit_q      <= 1'b0;
      old_any_q  <= 1'b0;
      free_any_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      cmp_vld_q  <= cmp_vld_d;
      valid_q    <= valid_d;
      occ_q      <= occ_d;
      hit_q      <= hit_d;
      old_any_q  <= old_any_d;
      free_any_q <= free_any_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    is_put_q   <= is_put_d;
    key_q      <= key_d;
    value_q    <= value_d;
    hit_idx_q  <= hit_idx_d;
    hit_age_q  <= hit_age_d;
    hit_val_q  <= hit_val_d;
    old_idx_q  <= old_idx_d;
    old_age_q  <= old_age_d;
    old_key_q  <= old_key_d;
    free_idx_q <= free_idx_d;
    tgt_idx_q  <= tgt_idx_d;
    rsp_q      <= rsp_d;
  end

  assign rsp_o = rsp_q;

  // occupancy tracks the number of valid entries
  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(occ_q))
    else $error("occupancy does not match valid entries");

  // occupancy moves only in the decide cycle
  a_occ_only_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StDecide |=> $stable(occ_q))
    else $error("occupancy changed outside decide");

  // a taken request always starts a scan
  a_pop_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |=> state_q == StScan && ptr_q == '0)
    else $error("request popped without scan");

  // eviction only on a put that missed with the table at capacity
  a_evict_on_put_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDecide && evict |-> is_put_q && !hit_q && occ_q != '0)
    else $error("eviction on a hit or a get");

  // an insert always has a slot to land in
  a_insert_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDecide && is_put_q && !hit_q |-> evict || free_any_q)
    else $error("insert without a free slot");

endmodule

// ===== sv/lru_key_value_cache_core.sv =====
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement.
// Input channel: drive cmd_i (0 get, 1 put), key_i and value_i with push high;
// the beat is taken at a clock edge where push is high and full is low. A
// two-entry request queue sits in front of the lookup engine.
// Result channel: while empty is low, found_o, data_o, evicted_o and
// evicted_key_o show the oldest result; it is taken at an edge where pop is
// high. Exactly one result comes back per request, in order.
// Capacity: cfg_we_i writes cfg_wdata_i into the capacity register (zero acts
// as one, values above MaxEntries act as MaxEntries); write only while idle.
// Engine: it reads one entry per cycle from the key and age memories and
// works through a request in order: a pop, a scan pass, a decide step, an
// age update pass (skipped for a get that misses) and a delivery. Requests
// are served one at a time. Reset empties the cache and sets capacity to
// its default. If the receiver stalls, the two-entry result queue fills,
// the engine holds its finished result, and full rises once the request
// queue is full as well.
module lru_key_value_cache_core #(
  parameter int MaxEntries = lkv_pkg::DefaultMaxEntries
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            push,
  output logic                            full,
  input  logic                            cmd_i,
  input  logic signed [lkv_pkg::KeyW-1:0] key_i,
  input  logic signed [lkv_pkg::DataW-1:0] value_i,
  // result channel
  output logic                            empty,
  input  logic                            pop,
  output logic                            found_o,
  output logic signed [lkv_pkg::DataW-1:0] data_o,
  output logic                            evicted_o,
  output logic signed [lkv_pkg::KeyW-1:0] evicted_key_o,
  // capacity register
  input  logic                            cfg_we_i,
  input  logic [lkv_pkg::CapW-1:0]        cfg_wdata_i
);

  localparam int CntW = $clog2(MaxEntries + 1);

  logic            req_valid;
  lkv_pkg::req_t   req;
  logic            req_pop;
  logic [CntW-1:0] cap;
  logic            rsp_full;
  logic            rsp_push;
  lkv_pkg::rsp_t   rsp_in;
  lkv_pkg::rsp_t   rsp_out;

  // accept and classify
  lkv_front #(
    .MaxEntries (MaxEntries),
    .QueueDepth (lkv_pkg::CmdQueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop),
    .cap_o       (cap)
  );

  // lookup and replacement engine
  lkv_back #(
    .MaxEntries (MaxEntries)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .cap_i       (cap),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp_in)
  );

  // result queue
  lkv_fifo #(
    .Width ($bits(lkv_pkg::rsp_t)),
    .Depth (lkv_pkg::RspQueueDepth)
  ) u_rsp_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .wdata_i (rsp_in),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .rdata_o (rsp_out),
    .empty_o (empty)
  );

  assign found_o       = rsp_out.found;
  assign data_o        = rsp_out.data;
  assign evicted_o     = rsp_out.evicted;
  assign evicted_key_o = rsp_out.evicted_key;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int KeyW         = lkv_pkg::KeyW;
  localparam int DataW        = lkv_pkg::DataW;
  localparam int CapW         = lkv_pkg::CapW;
  localparam int Entries      = lkv_pkg::DefaultMaxEntries;
  // one request: pop, scan pass, decide, age update pass, delivery
  localparam int AccessCycles = 2 * Entries + 5;
  localparam int IdleLimit    = 4000;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             push      = 1'b0;
  logic             cmd       = 1'b0;
  logic [KeyW-1:0]  key       = '0;
  logic [DataW-1:0] value     = '0;
  logic             pop       = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CapW-1:0]  cfg_wdata = '0;

  wire              full;
  wire              empty;
  wire              found;
  wire [DataW-1:0]  data;
  wire              evicted;
  wire [KeyW-1:0]   evicted_key;

  lru_key_value_cache_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd),
    .key_i        (key),
    .value_i      (value),
    .empty        (empty),
    .pop          (pop),
    .found_o      (found),
    .data_o       (data),
    .evicted_o    (evicted),
    .evicted_key_o(evicted_key),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // shadow copy of the cache contents and the capacity register
  logic [KeyW-1:0]  line_key   [Entries];
  logic [DataW-1:0] line_val   [Entries];
  bit               line_valid [Entries];
  int               line_age   [Entries];
  int               lines_used = 0;
  logic [CapW-1:0]  cap_reg    = CapW'(lkv_pkg::DefaultCapacity);

  // lookup results still owed by the cache, oldest first
  lkv_pkg::rsp_t    lookups_due[$];
  int               errors      = 0;
  int               burst_left  = 0;
  int               idle_cycles = 0;
  int               stall_mode  = 0;
  int               stall_left  = 0;

  // move one line to the front, lines younger than it age by one
  function automatic void make_recent(int idx);
    int a;
    int i;
    a = line_age[idx];
    for (i = 0; i < Entries; i++)
      if (line_valid[i] && line_age[i] < a) line_age[i]++;
    line_age[idx] = 0;
  endfunction

  // apply one get or put to the shadow cache and return what the block must report
  function automatic lkv_pkg::rsp_t cache_access(lkv_pkg::op_e op, logic [KeyW-1:0] k,
                                                 logic [DataW-1:0] v);
    lkv_pkg::rsp_t r;
    int   hit;
    int   slot;
    int   limit;
    int   i;
    r    = '0;
    hit  = -1;
    slot = -1;
    for (i = 0; i < Entries; i++)
      if (hit < 0 && line_valid[i] && line_key[i] == k) hit = i;
    if (op == lkv_pkg::OpGet) begin
      if (hit >= 0) begin
        r.found = 1'b1;
        r.data  = line_val[hit];
        make_recent(hit);
      end else begin
        r.data = lkv_pkg::MissData;
      end
    end else if (hit >= 0) begin
      r.found       = 1'b1;
      line_val[hit] = v;
      make_recent(hit);
    end else begin
      // zero acts as one, anything above the table size acts as the table size
      limit = (cap_reg == 0) ? 1 : ((int'(cap_reg) > Entries) ? Entries : int'(cap_reg));
      if (lines_used >= limit) begin
        for (i = 0; i < Entries; i++)
          if (line_valid[i] && (slot < 0 || line_age[i] > line_age[slot])) slot = i;
        if (slot >= 0) begin
          r.evicted        = 1'b1;
          r.evicted_key    = line_key[slot];
          line_valid[slot] = 1'b0;
          lines_used--;
        end
      end
      if (slot < 0)
        for (i = 0; i < Entries; i++)
          if (slot < 0 && !line_valid[i]) slot = i;
      if (slot >= 0) begin
        for (i = 0; i < Entries; i++)
          if (line_valid[i]) line_age[i]++;
        line_key[slot]   = k;
        line_val[slot]   = v;
        line_valid[slot] = 1'b1;
        line_age[slot]   = 0;
        lines_used++;
      end
    end
    return r;
  endfunction

  // send one request beat, in bursts with random gaps between them
  task automatic send_access(lkv_pkg::op_e op, logic [KeyW-1:0] k, logic [DataW-1:0] v);
    int gap;
    lkv_pkg::rsp_t due;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 45);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push  <= 1'b1;
    cmd   <= op;
    key   <= k;
    value <= v;
    do @(posedge clk); while (full);
    due = cache_access(op, k, v);
    lookups_due.insert(lookups_due.size(), due);
  endtask

  // stop sending and wait until the cache has answered everything
  task automatic settle_cache();
    @(negedge clk);
    push <= 1'b0;
    burst_left = 0;
    while (lookups_due.size() != 0) @(posedge clk);
    repeat (AccessCycles + 4) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CapW-1:0] c);
    settle_cache();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cap_reg = c;
  endtask

  // gets on an empty cache, extreme keys
  task automatic test_empty_misses();
    send_access(lkv_pkg::OpGet, 32'h8000_0000, 32'h0);
    send_access(lkv_pkg::OpGet, 32'h7fff_ffff, 32'hffff_ffff);
  endtask

  // inserts, hits, a miss and an update of a present key
  task automatic test_put_update_hit();
    send_access(lkv_pkg::OpPut, 32'h8000_0000, 32'h7fff_ffff);
    send_access(lkv_pkg::OpPut, 32'h7fff_ffff, 32'h8000_0000);
    send_access(lkv_pkg::OpPut, 32'h0000_0000, 32'h0000_0000);
    send_access(lkv_pkg::OpPut, 32'hffff_ffff, 32'hffff_ffff);
    send_access(lkv_pkg::OpGet, 32'h8000_0000, 32'h0);
    send_access(lkv_pkg::OpPut, 32'h7fff_ffff, 32'h5a5a_5a5a);
    send_access(lkv_pkg::OpGet, 32'h7fff_ffff, 32'h0);
    send_access(lkv_pkg::OpGet, 32'h0000_3039, 32'h0);
  endtask

  // capacity below occupancy, zero capacity, capacity above the table size
  task automatic test_capacity_limits();
    set_capacity(5'd2);
    send_access(lkv_pkg::OpPut, 32'h0000_0001, 32'h1111_1111);
    send_access(lkv_pkg::OpPut, 32'h0000_0002, 32'h2222_2222);
    set_capacity(5'd0);
    send_access(lkv_pkg::OpPut, 32'h0000_0003, 32'h3333_3333);
    send_access(lkv_pkg::OpGet, 32'h0000_0003, 32'h0);
    send_access(lkv_pkg::OpGet, 32'h0000_0001, 32'h0);
    set_capacity(5'd31);
    send_access(lkv_pkg::OpPut, 32'h0000_0004, 32'h4444_4444);
    send_access(lkv_pkg::OpPut, 32'h0000_0005, 32'h5555_5555);
    send_access(lkv_pkg::OpPut, 32'h0000_0006, 32'h6666_6666);
    send_access(lkv_pkg::OpGet, 32'hffff_ffff, 32'h0);
  endtask

  // random gets and puts over a small key pool per capacity setting
  task automatic test_random_traffic();
    logic [CapW-1:0] caps[10];
    logic [KeyW-1:0] pool[$];
    logic [KeyW-1:0] k;
    int              eff;
    int              p;
    int              j;
    caps = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd12, 5'd16};
    caps[5] = $urandom_range(3, 15);
    caps[8] = $urandom_range(1, 31);
    for (p = 0; p < 10; p++) begin
      set_capacity(caps[p]);
      eff = (caps[p] == 0) ? 1 : ((int'(caps[p]) > Entries) ? Entries : int'(caps[p]));
      pool.delete();
      for (j = 0; j < eff + $urandom_range(1, 6); j++) begin
        case ($urandom_range(0, 3))
          0:       k = $urandom;
          1:       k = $urandom_range(0, 31);
          2:       k = 32'h8000_0000 + j;
          default: k = 32'hffff_ffff - j;
        endcase
        pool.insert(pool.size(), k);
      end
      for (j = 0; j < 190; j++) begin
        if ($urandom_range(0, 99) < 8) k = $urandom;
        else k = pool[$urandom_range(0, pool.size() - 1)];
        send_access($urandom_range(0, 1) ? lkv_pkg::OpPut : lkv_pkg::OpGet, k, $urandom);
      end
    end
  endtask

  // receiver: pop pattern changes in stretches, from never stalling to fully stalled
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(40, 300);
    end
    stall_left--;
    case (stall_mode)
      0:       pop <= 1'b1;
      1:       pop <= ($urandom_range(0, 2) != 0);
      2:       pop <= ((stall_left % 7) < 2);
      default: pop <= 1'b0;
    endcase
  end

  // compare each result beat with the oldest pending lookup
  always @(posedge clk) begin
    lkv_pkg::rsp_t due;
    if (rst_n && pop && !empty) begin
      if (lookups_due.size() == 0) begin
        $error("result beat with no lookup pending");
        errors++;
      end else begin
        due = lookups_due.pop_front();
        if (found !== due.found) begin
          $error("found mismatch: expected %0b, actual %0b", due.found, found);
          errors++;
        end
        if (data !== due.data) begin
          $error("data mismatch: expected %h, actual %h", due.data, data);
          errors++;
        end
        if (evicted !== due.evicted) begin
          $error("evicted mismatch: expected %0b, actual %0b", due.evicted, evicted);
          errors++;
        end
        if (evicted_key !== due.evicted_key) begin
          $error("evicted_key mismatch: expected %h, actual %h", due.evicted_key,
                 evicted_key);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_misses();
    test_put_update_hit();
    test_capacity_limits();
    test_random_traffic();
    settle_cache();
    if (lookups_due.size() != 0) begin
      $error("%0d lookups never answered", lookups_due.size());
      errors++;
    end
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lkv_pkg.sv
sv/lkv_ram.sv
sv/lkv_fifo.sv
sv/lkv_front.sv
sv/lkv_back.sv
sv/lru_key_value_cache_core.sv
bench/testbench.sv
